// ----- sv/hbsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_pkg
// Shared types, sizes and codes of the bucketed entry store.
// ----------------------------------------------------------------------------
package hbsr_pkg;

   localparam int WAYS         = 4;
   localparam int BUCKET_COUNT = 1024;

   localparam int IDX_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_STORE  = 1'b1;

   localparam int   CSR_ADDR_W       = 3;
   localparam logic REG_BOUND_MATRIX = 1'b0;

   typedef struct packed {
      logic        [63:0] key;
      logic signed [15:0] value;
      logic signed [15:0] age;
      logic signed [7:0]  depth;
      logic        [1:0]  bound;
      logic        [31:0] move;
   } entry_type;

   typedef struct packed {
      logic [FILL_W-1:0]          fill;
      entry_type [WAYS-1:0]       slots;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic             capture;
      logic             eval;
      logic             clear_wr;
      logic [IDX_W-1:0] clear_addr;
   } dp_cmd_type;

   typedef struct packed {
      logic               hit;
      logic               written;
      logic        [1:0]  way;
      logic signed [15:0] found_value;
      logic signed [15:0] found_age;
      logic signed [7:0]  found_depth;
      logic        [1:0]  found_bound;
      logic        [31:0] found_move;
   } rsp_type;

   function automatic logic better(input logic [15:0] matrix, input logic [1:0] nb,
                                   input logic [1:0] ob);
      return matrix[{nb, ob}];
   endfunction

endpackage

// ----- sv/hbsr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_if
// Valid/ready channels for requests and responses of the entry store.
// ----------------------------------------------------------------------------
interface hbsr_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic        [9:0]  bucket_index;
   logic        [63:0] entry_key;
   logic signed [15:0] entry_value;
   logic signed [15:0] entry_age;
   logic signed [7:0]  entry_depth;
   logic        [1:0]  entry_bound;
   logic        [31:0] entry_move;

   modport source (output valid, action, bucket_index, entry_key, entry_value, entry_age,
                   entry_depth, entry_bound, entry_move, input ready);
   modport sink (input valid, action, bucket_index, entry_key, entry_value, entry_age,
                 entry_depth, entry_bound, entry_move, output ready);
endinterface

interface hbsr_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic               written;
   logic        [1:0]  way;
   logic signed [15:0] found_value;
   logic signed [15:0] found_age;
   logic signed [7:0]  found_depth;
   logic        [1:0]  found_bound;
   logic        [31:0] found_move;

   modport source (output valid, hit, written, way, found_value, found_age, found_depth,
                   found_bound, found_move, input ready);
   modport sink (input valid, hit, written, way, found_value, found_age, found_depth,
                 found_bound, found_move, output ready);
endinterface

// ----- sv/hbsr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hbsr_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_csr
// APB register block holding the bound preference matrix.
// ----------------------------------------------------------------------------
module hbsr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hbsr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic [15:0]                    bound_matrix
);
   import hbsr_pkg::*;

   logic [15:0] matrix_ff;
   logic [15:0] matrix_in;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_BOUND_MATRIX);

   always_comb begin
      matrix_in = matrix_ff;
      if (psel && penable && pwrite && reg_sel) begin
         matrix_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign prdata       = reg_sel ? {16'd0, matrix_ff} : 32'd0;
   assign bound_matrix = matrix_ff;

endmodule

// ----- sv/hbsr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_ctrl
// Sequencer: post-reset clearing pass, request accept, bucket evaluation.
// ----------------------------------------------------------------------------
module hbsr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hbsr_pkg::dp_cmd_type     cmd
);
   import hbsr_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_ready      = 1'b0;
      cmd.capture    = 1'b0;
      cmd.eval       = 1'b0;
      cmd.clear_wr   = 1'b0;
      cmd.clear_addr = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.eval = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.eval) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/hbsr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_dp
// Bucket memory, way compare, replacement choice and response register.
// ----------------------------------------------------------------------------
module hbsr_dp (
   input  logic                       clock,
   input  hbsr_pkg::dp_cmd_type       cmd,
   input  logic [15:0]                bound_matrix,
   input  logic                       action,
   input  logic [9:0]                 bucket_index,
   input  logic [63:0]                entry_key,
   input  logic signed [15:0]         entry_value,
   input  logic signed [15:0]         entry_age,
   input  logic signed [7:0]          entry_depth,
   input  logic [1:0]                 entry_bound,
   input  logic [31:0]                entry_move,
   output hbsr_pkg::rsp_type          rsp_data
);
   import hbsr_pkg::*;

   logic             action_ff;
   logic [IDX_W-1:0] bucket_ff;
   entry_type        new_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [IDX_W-1:0] rd_addr;
   logic [ROW_W-1:0] rd_data;
   row_type          row;
   row_type          new_row;
   logic             row_wr;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;

   assign rd_addr = IDX_W'(bucket_index % BUCKET_COUNT);
   assign row     = row_type'(rd_data);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action;
         bucket_ff <= rd_addr;
         new_ff    <= '{key: entry_key, value: entry_value, age: entry_age,
                        depth: entry_depth, bound: entry_bound, move: entry_move};
      end
      if (cmd.eval) begin
         rsp_ff <= rsp_in;
      end
   end

   hbsr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKET_COUNT)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [FILL_W-1:0] size;
      logic [WAYS-1:0]   match;
      logic              found;
      logic [WAY_W-1:0]  match_idx;
      logic [WAY_W-1:0]  rep_idx;
      logic [WAY_W-1:0]  wr_idx;
      logic              improve;
      entry_type         m_slot;
      entry_type         e_slot;
      entry_type         r_slot;

      size = (row.fill > FILL_W'(WAYS)) ? FILL_W'(WAYS) : row.fill;
      for (int i = 0; i < WAYS; i++) begin
         match[i] = (FILL_W'(i) < size) && (row.slots[i].key == new_ff.key);
      end
      found     = |match;
      match_idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = WAY_W'(i);
         end
      end
      m_slot  = row.slots[match_idx];
      improve = (m_slot.depth < new_ff.depth) ||
                ((m_slot.depth == new_ff.depth) &&
                 better(bound_matrix, new_ff.bound, m_slot.bound));

      // full bucket: least age, then least depth, then worse bound
      rep_idx = '0;
      for (int i = 1; i < WAYS; i++) begin
         e_slot = row.slots[i];
         r_slot = row.slots[rep_idx];
         if ((e_slot.age < r_slot.age) ||
             ((e_slot.age == r_slot.age) &&
              ((e_slot.depth < r_slot.depth) ||
               ((e_slot.depth == r_slot.depth) &&
                better(bound_matrix, r_slot.bound, e_slot.bound))))) begin
            rep_idx = WAY_W'(i);
         end
      end

      new_row = row;
      row_wr  = 1'b0;
      wr_idx  = match_idx;
      rsp_in  = '0;
      if (action_ff == ACT_LOOKUP) begin
         if (found) begin
            rsp_in.hit         = 1'b1;
            rsp_in.way         = 2'(match_idx);
            rsp_in.found_value = m_slot.value;
            rsp_in.found_age   = m_slot.age;
            rsp_in.found_depth = m_slot.depth;
            rsp_in.found_bound = m_slot.bound;
            rsp_in.found_move  = m_slot.move;
         end
      end else begin
         if (found) begin
            rsp_in.hit = 1'b1;
            rsp_in.way = 2'(match_idx);
            row_wr     = improve;
         end else if (size < FILL_W'(WAYS)) begin
            wr_idx       = WAY_W'(size);
            new_row.fill = size + 1'b1;
            rsp_in.way   = 2'(wr_idx);
            row_wr       = 1'b1;
         end else begin
            wr_idx     = rep_idx;
            rsp_in.way = 2'(rep_idx);
            row_wr     = 1'b1;
         end
         rsp_in.written = row_wr;
      end
      new_row.slots[wr_idx] = new_ff;
   end

   assign ram_wr_en   = cmd.clear_wr || (cmd.eval && row_wr);
   assign ram_wr_addr = cmd.clear_wr ? cmd.clear_addr : bucket_ff;
   assign ram_wr_data = cmd.clear_wr ? '0 : ROW_W'(new_row);

   assign rsp_data = rsp_ff;

endmodule

// ----- sv/hash_bucket_store_replace.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_bucket_store_replace
// Bucketed keyed-entry store with depth-preferred replacement.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all BUCKET_COUNT (1024) buckets
// that zeroes every bucket's fill count; req_chan.ready stays low until it ends,
// while csr writes are taken as usual. Each transaction then passes through
// the accept state, which reads the whole bucket row (all ways plus fill count)
// from a single-port-read bucket memory, and the evaluation state, which
// compares every way at once, writes the row back when a store changes it and
// loads the response register. A new request is accepted in the cycle after
// that, even when the previous response is still waiting; a response that is
// not taken holds the evaluation until it is. The bucket row read-modify-write
// through one memory keeps one transaction in flight at a time, and a later
// access to the same bucket always sees the earlier write.
module hash_bucket_store_replace (
   input  logic                            clock,
   input  logic                            reset,
   hbsr_req_if.sink                        req_chan,
   hbsr_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hbsr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import hbsr_pkg::*;

   logic        [15:0] bound_matrix;
   dp_cmd_type         dp_cmd;
   rsp_type            rsp_data;
   logic               req_ready;
   logic               rsp_valid;

   hbsr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .bound_matrix (bound_matrix)
   );

   hbsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd)
   );

   hbsr_dp u_dp (
      .clock        (clock),
      .cmd          (dp_cmd),
      .bound_matrix (bound_matrix),
      .action       (req_chan.action),
      .bucket_index (req_chan.bucket_index),
      .entry_key    (req_chan.entry_key),
      .entry_value  (req_chan.entry_value),
      .entry_age    (req_chan.entry_age),
      .entry_depth  (req_chan.entry_depth),
      .entry_bound  (req_chan.entry_bound),
      .entry_move   (req_chan.entry_move),
      .rsp_data     (rsp_data)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.hit         = rsp_data.hit;
   assign rsp_chan.written     = rsp_data.written;
   assign rsp_chan.way         = rsp_data.way;
   assign rsp_chan.found_value = rsp_data.found_value;
   assign rsp_chan.found_age   = rsp_data.found_age;
   assign rsp_chan.found_depth = rsp_data.found_depth;
   assign rsp_chan.found_bound = rsp_data.found_bound;
   assign rsp_chan.found_move  = rsp_data.found_move;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_wr |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> (!req_ready && !dp_cmd.clear_wr))
      else $error("second request accepted while bucket evaluation pending");

   a_eval_loads_response: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.eval |=> rsp_valid)
      else $error("evaluated transaction produced no response");

   a_miss_way_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit && !rsp_data.written) |-> (rsp_data.way == 2'd0))
      else $error("lookup miss reports a nonzero way");

endmodule

// ----- tb/sv/hbsr_store_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsr_store_checker
// Watches the request, response and csr ports of the bucketed entry store,
// keeps its own copy of every bucket and of the bound matrix, predicts the
// response of each accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module hbsr_store_checker (
   input  logic                            clock,
   input  logic                            reset,
   hbsr_req_if                             req_mon,
   hbsr_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hbsr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              pending
);
   import hbsr_pkg::*;

   logic [15:0]       bound_matrix;
   logic [FILL_W-1:0] fill_cnt [BUCKET_COUNT];
   entry_type         slot_mem [BUCKET_COUNT * WAYS];
   rsp_type           bucket_outcomes [$];
   rsp_type           want;
   entry_type         incoming;

   function automatic bit outranks(input logic [1:0] nb, input logic [1:0] ob);
      return bound_matrix[{nb, ob}];
   endfunction

   function automatic rsp_type access_bucket(input logic act, input logic [IDX_W-1:0] bkt,
                                             input entry_type ent);
      rsp_type   res;
      entry_type cur;
      entry_type cand;
      int        row;
      int        base;
      int        used;
      int        hit_way;
      int        victim;
      int        i;
      bit        matched;
      res     = '0;
      matched = 1'b0;
      hit_way = 0;
      row     = int'(bkt) % BUCKET_COUNT;
      base    = row * WAYS;
      used    = fill_cnt[row];
      if (used > WAYS) used = WAYS;
      for (i = 0; i < used && !matched; i++) begin
         if (slot_mem[base + i].key == ent.key) begin
            matched = 1'b1;
            hit_way = i;
         end
      end
      if (act == ACT_LOOKUP) begin
         if (matched) begin
            cur             = slot_mem[base + hit_way];
            res.hit         = 1'b1;
            res.way         = hit_way[1:0];
            res.found_value = cur.value;
            res.found_age   = cur.age;
            res.found_depth = cur.depth;
            res.found_bound = cur.bound;
            res.found_move  = cur.move;
         end
         return res;
      end
      if (matched) begin
         cur     = slot_mem[base + hit_way];
         res.hit = 1'b1;
         res.way = hit_way[1:0];
         if (cur.depth < ent.depth ||
             (cur.depth == ent.depth && outranks(ent.bound, cur.bound))) begin
            slot_mem[base + hit_way] = ent;
            res.written = 1'b1;
         end
      end else if (used < WAYS) begin
         slot_mem[base + used] = ent;
         fill_cnt[row] = FILL_W'(used + 1);
         res.written   = 1'b1;
         res.way       = used[1:0];
      end else begin
         // least age, then least depth, then worse bound; earliest way on ties
         victim = 0;
         for (i = 1; i < WAYS; i++) begin
            cand = slot_mem[base + i];
            cur  = slot_mem[base + victim];
            if (cand.age < cur.age ||
                (cand.age == cur.age &&
                 (cand.depth < cur.depth ||
                  (cand.depth == cur.depth && outranks(cur.bound, cand.bound)))))
               victim = i;
         end
         slot_mem[base + victim] = ent;
         res.written = 1'b1;
         res.way     = victim[1:0];
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         failures++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         bound_matrix = '0;
         foreach (fill_cnt[i]) fill_cnt[i] = '0;
         bucket_outcomes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bucket_outcomes.size() == 0) begin
               failures++;
               $display({"%0t: unexpected transaction, expected none, ",
                         "actual hit %0b written %0b way %0d"},
                        $time, rsp_mon.hit, rsp_mon.written, rsp_mon.way);
            end else begin
               want = bucket_outcomes.pop_front();
               check_field("hit", want.hit, rsp_mon.hit);
               check_field("written", want.written, rsp_mon.written);
               check_field("way", want.way, rsp_mon.way);
               check_field("found_value", want.found_value, rsp_mon.found_value);
               check_field("found_age", want.found_age, rsp_mon.found_age);
               check_field("found_depth", want.found_depth, rsp_mon.found_depth);
               check_field("found_bound", want.found_bound, rsp_mon.found_bound);
               check_field("found_move", want.found_move, rsp_mon.found_move);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            incoming = '{key: req_mon.entry_key, value: req_mon.entry_value,
                         age: req_mon.entry_age, depth: req_mon.entry_depth,
                         bound: req_mon.entry_bound, move: req_mon.entry_move};
            bucket_outcomes.push_back(access_bucket(req_mon.action, req_mon.bucket_index,
                                                    incoming));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1] == REG_BOUND_MATRIX)
            bound_matrix = csr_pwdata[15:0];
      end
      pending = bucket_outcomes.size();
   end

endmodule

// ----- tb/sv/hash_bucket_store_replace_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_bucket_store_replace_tb
// Drives lookups and stores into the bucketed entry store: a directed run over
// appends, improving and non-improving overwrites and full-bucket replacement,
// then random phases on a few busy buckets under several bound matrices, with
// random idling on both channels, a long response stall and a no-idle phase.
// ----------------------------------------------------------------------------
module hash_bucket_store_replace_tb;
   import hbsr_pkg::*;

   localparam int STALL_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_ITEMS     = 250;

   localparam logic [CSR_ADDR_W-1:0] MATRIX_ADDR = CSR_ADDR_W'(4 * int'(REG_BOUND_MATRIX));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR  =
      CSR_ADDR_W'(4 * (int'(REG_BOUND_MATRIX) + 1));

   // bound n better than bound o when n > o
   localparam logic [31:0] ORDERED_BOUNDS = 32'h0000_7310;

   localparam logic [63:0] KEY_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_MIX  = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] KEY_XIM  = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] KEY_EDGE = 64'h8000_0000_0000_0001;

   localparam logic [IDX_W-1:0] TOP_BUCKET = '1;
   localparam logic [IDX_W-1:0] LOW_BUCKET = '0;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] bucket;
      entry_type        ent;
   } request_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int          check_failures;
   int          outstanding;
   int          idle_pct = 35;
   int          stall_cycles = 0;
   int          hold_rsp_reqs = 0;
   logic [63:0] key_pool [12];
   logic [IDX_W-1:0] hot_buckets [8];

   hbsr_req_if req_chan ();
   hbsr_rsp_if rsp_chan ();

   hash_bucket_store_replace i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   hbsr_store_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (check_failures),
      .pending     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic request_type compose(input logic act, input logic [IDX_W-1:0] bkt,
                                           input logic [63:0] key, input logic [15:0] value,
                                           input logic [15:0] age, input logic [7:0] depth,
                                           input logic [1:0] bound, input logic [31:0] move);
      request_type rq;
      rq.action    = act;
      rq.bucket    = bkt;
      rq.ent.key   = key;
      rq.ent.value = value;
      rq.ent.age   = age;
      rq.ent.depth = depth;
      rq.ent.bound = bound;
      rq.ent.move  = move;
      return rq;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.action    = ($urandom_range(0, 99) < 55) ? ACT_STORE : ACT_LOOKUP;
      rq.bucket    = ($urandom_range(0, 99) < 85) ? hot_buckets[$urandom_range(0, 7)]
                                                  : IDX_W'($urandom());
      rq.ent.key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 11)]
                                                  : {$urandom(), $urandom()};
      rq.ent.value = 16'($urandom());
      rq.ent.age   = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom());
      rq.ent.depth = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 4)) - 8'd2
                                                  : 8'($urandom());
      rq.ent.bound = 2'($urandom());
      rq.ent.move  = $urandom();
      return rq;
   endfunction

   task automatic put_request(input request_type rq);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= rq.action;
      req_chan.bucket_index <= rq.bucket;
      req_chan.entry_key    <= rq.ent.key;
      req_chan.entry_value  <= rq.ent.value;
      req_chan.entry_age    <= rq.ent.age;
      req_chan.entry_depth  <= rq.ent.depth;
      req_chan.entry_bound  <= rq.ent.bound;
      req_chan.entry_move   <= rq.ent.move;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) put_request(random_request());
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // response side, with a long hold-off when asked for
   initial begin
      int hold_served;
      hold_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_reqs != hold_served) begin
            hold_served = hold_rsp_reqs;
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.action       <= ACT_LOOKUP;
      req_chan.bucket_index <= '0;
      req_chan.entry_key    <= '0;
      req_chan.entry_value  <= '0;
      req_chan.entry_age    <= '0;
      req_chan.entry_depth  <= '0;
      req_chan.entry_bound  <= '0;
      req_chan.entry_move   <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;

      key_pool[0] = KEY_ZERO;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < 12; i++) key_pool[i] = {$urandom(), $urandom()};
      hot_buckets[0] = LOW_BUCKET;
      hot_buckets[1] = TOP_BUCKET;
      for (int i = 2; i < 8; i++) hot_buckets[i] = IDX_W'($urandom_range(1, BUCKET_COUNT - 2));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // register writes are taken during the clearing pass
      csr_write(MATRIX_ADDR, ORDERED_BOUNDS);
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);

      // empty bucket, append, lookups, stores that do and do not improve
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_ZERO, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ZERO, 16'h8000, 16'h7FFF, 8'h7F, 2'd0,
                          32'hFFFF_FFFF));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_ZERO, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ZERO, 16'h1234, 16'h0, 8'h7E, 2'd3,
                          32'h1));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ZERO, 16'h1234, 16'h0, 8'h7F, 2'd0,
                          32'h2));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ZERO, 16'h7FFF, 16'h7FFF, 8'h7F, 2'd3,
                          32'h0));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_ZERO, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      // fill the bucket, then replace into it
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ONES, 16'h0001, 16'h0005, 8'h80, 2'd1,
                          32'hA5A5_A5A5));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_MIX, 16'hFFFF, 16'h0005, 8'h80, 2'd2,
                          32'h5A5A_5A5A));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_XIM, 16'h0002, 16'h0005, 8'h00, 2'd3,
                          32'h0000_FFFF));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_XIM, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_EDGE, 16'h0003, 16'h7FFF, 8'h01, 2'd0,
                          32'hFFFF_0000));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_ONES, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_EDGE, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_STORE, TOP_BUCKET, KEY_ONES, 16'h0004, 16'h0005, 8'h80, 2'd3,
                          32'h8000_0001));
      put_request(compose(ACT_LOOKUP, TOP_BUCKET, KEY_MIX, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      // lowest bucket, most negative age and depth
      put_request(compose(ACT_STORE, LOW_BUCKET, KEY_ONES, 16'h0000, 16'h8000, 8'h80, 2'd0,
                          32'h0));
      put_request(compose(ACT_LOOKUP, LOW_BUCKET, KEY_ONES, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_LOOKUP, LOW_BUCKET, KEY_MIX, 16'h0, 16'h0, 8'h0, 2'd0, 32'h0));
      put_request(compose(ACT_STORE, LOW_BUCKET, KEY_ONES, 16'h7FFF, 16'h7FFF, 8'h80, 2'd1,
                          32'h0));
      put_request(compose(ACT_STORE, LOW_BUCKET, KEY_ONES, 16'h7FFF, 16'h7FFF, 8'h80, 2'd0,
                          32'h0));
      drain();

      csr_write(MATRIX_ADDR, 32'h0000_0000);
      run_random(PHASE_ITEMS);
      drain();

      csr_write(MATRIX_ADDR, 32'hFFFF_FFFF);
      hold_rsp_reqs++;
      run_random(PHASE_ITEMS);
      drain();

      idle_pct = 0;
      csr_write(MATRIX_ADDR, $urandom());
      run_random(PHASE_ITEMS);
      drain();

      idle_pct = 35;
      csr_write(MATRIX_ADDR, ORDERED_BOUNDS);
      run_random(PHASE_ITEMS);
      drain();

      csr_write(MATRIX_ADDR, $urandom());
      run_random(PHASE_ITEMS);
      drain();

      if (check_failures == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/hbsr_pkg.sv
sv/hbsr_if.sv
sv/hbsr_ram.sv
sv/hbsr_csr.sv
sv/hbsr_ctrl.sv
sv/hbsr_dp.sv
sv/hash_bucket_store_replace.sv
tb/sv/hbsr_store_checker.sv
tb/sv/hash_bucket_store_replace_tb.sv
